/* sv/linear_interp_resampler_core_assert.svh */
// assertion macros for the linear interpolation resampler checker
// no dependencies; included by the checker file only
`ifndef LINEAR_INTERP_RESAMPLER_CORE_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_ASSERT_SVH

// next-cycle implication, masked while reset is low
`define LIRS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("resampler assertion failed");

// next-cycle implication that also holds through reset
`define LIRS_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("resampler assertion failed");

`endif

/* sv/lirs_pkg.sv */
// shared constants and types for the linear interpolation resampler
// no dependencies; used by the top level, front end, back end and checker
package lirs_pkg;

    localparam int PHASE_FRAC_BITS = 16;
    localparam int STEP_BITS       = 21;
    localparam int CHAN_CNT_BITS   = 4;
    localparam int CH_FIELD_BITS   = 4;
    localparam int OUT_CH_BITS     = 3;
    localparam int CFG_IDX_BITS    = 1;
    localparam int ONE_FRAME       = 1 << PHASE_FRAC_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_RATIO = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CHANS  = 1'd1;

    localparam logic [STEP_BITS-1:0]     STEP_RESET = 21'd65536;
    localparam logic [CHAN_CNT_BITS-1:0] CHAN_RESET = 4'd1;

    // classification of one sample, passed from the front end to the back end
    typedef struct packed {
        logic                     restart;
        logic                     complete;
        logic [CH_FIELD_BITS-1:0] slot;
        logic [CH_FIELD_BITS-1:0] chan_last;
    } lirs_ctrl_t;

endpackage

/* sv/linear_interp_resampler_core.sv */
// top level of the linear interpolation resampler: config registers, front end,
// request queue and back end; depends on lirs_pkg, lirs_front, lirs_fifo, lirs_back
// a non-closing sample takes the back end's idle state only; a closing sample adds the
// frame state, then per result a multiply state and an output state (add into the output
// register, waiting on a stalled output); the 2-entry queue takes samples while results
// drain; sync active-low reset clears control state and history, not the data registers
module linear_interp_resampler_core #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_UPSAMPLE = 8,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
    input  logic                                s_tuser,  // restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,  // out_sample
    output logic [lirs_pkg::OUT_CH_BITS-1:0]    m_tuser,  // out_channel
    output logic                                m_tlast,  // last_of_run
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lirs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lirs_pkg::STEP_BITS-1:0]      cfg_data
);

    localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CTRL_W     = $bits(lirs_pkg::lirs_ctrl_t);
    localparam int ENTRY_W    = SAMPLE_BITS + CTRL_W;
    localparam int QUEUE_DEPTH = 2;

    logic [lirs_pkg::STEP_BITS-1:0]     step_ratio_reg;
    logic [lirs_pkg::CHAN_CNT_BITS-1:0] num_chans_reg;

    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_not_empty;
    logic [SAMPLE_BITS-1:0] push_sample;
    lirs_pkg::lirs_ctrl_t   push_ctrl;
    logic [ENTRY_W-1:0]     push_entry;
    logic [ENTRY_W-1:0]     pop_entry;
    lirs_pkg::lirs_ctrl_t   pop_ctrl;
    logic [SAMPLE_BITS-1:0] pop_sample;
    logic [SAMPLE_BITS-1:0] out_sample;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ratio_reg <= lirs_pkg::STEP_RESET;
            num_chans_reg  <= lirs_pkg::CHAN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lirs_pkg::REG_STEP_RATIO: begin
                    step_ratio_reg <= cfg_data;
                end
                lirs_pkg::REG_NUM_CHANS: begin
                    num_chans_reg <= cfg_data[lirs_pkg::CHAN_CNT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    lirs_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_sample      (s_tdata[SAMPLE_BITS-1:0]),
        .s_restart     (s_tuser),
        .num_chans     (num_chans_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_sample      (push_sample),
        .q_ctrl        (push_ctrl)
    );

    assign push_entry = {push_sample, push_ctrl};

    lirs_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_entry)
    );

    assign pop_sample = pop_entry[ENTRY_W-1:CTRL_W];
    assign pop_ctrl   = pop_entry[CTRL_W-1:0];

    lirs_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_not_empty),
        .q_sample   (pop_sample),
        .q_ctrl     (pop_ctrl),
        .q_pop      (q_pop),
        .step_ratio (step_ratio_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_sample   (out_sample),
        .m_channel  (m_tuser),
        .m_last     (m_tlast)
    );

    assign m_tdata = DATA_W'(out_sample);

endmodule

/* sv/lirs_front.sv */
// front end: accepts samples, tracks the channel slot and marks frame ends
// depends on lirs_pkg
module lirs_front #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [SAMPLE_BITS-1:0]              s_sample,
    input  logic                                s_restart,
    input  logic [lirs_pkg::CHAN_CNT_BITS-1:0]  num_chans,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [SAMPLE_BITS-1:0]              q_sample,
    output lirs_pkg::lirs_ctrl_t                q_ctrl
);

    localparam int EFF_CH = MAX_CHANNELS < 15 ? MAX_CHANNELS : 15;
    localparam int CH_W   = EFF_CH > 1 ? $clog2(EFF_CH) : 1;

    logic [CH_W-1:0] slot_reg;
    logic [CH_W-1:0] slot_next;
    logic [CH_W-1:0] slot_use;
    logic [CH_W-1:0] chans_m1;
    logic            complete;

    always_comb begin
        if (num_chans == '0) begin
            chans_m1 = '0;
        end else if (num_chans > lirs_pkg::CHAN_CNT_BITS'(EFF_CH)) begin
            chans_m1 = CH_W'(EFF_CH - 1);
        end else begin
            chans_m1 = CH_W'(num_chans - 1'b1);
        end
    end

    assign slot_use = s_restart ? '0 : slot_reg;
    // a lowered channel count closes the frame at the current slot
    assign complete = slot_use >= chans_m1;
    assign slot_next = complete ? '0 : CH_W'(slot_use + 1'b1);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_sample = s_sample;

    always_comb begin
        q_ctrl.restart   = s_restart;
        q_ctrl.complete  = complete;
        q_ctrl.slot      = lirs_pkg::CH_FIELD_BITS'(slot_use);
        q_ctrl.chan_last = lirs_pkg::CH_FIELD_BITS'(chans_m1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (q_push) begin
            slot_reg <= slot_next;
        end
    end

endmodule

/* sv/lirs_fifo.sv */
// short request queue between the front end and the back end
// no package dependency
module lirs_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop) begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end else if (do_pop && !do_push) begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

/* sv/lirs_back.sv */
// back end: frame history, phase accumulator and the interpolation datapath
// depends on lirs_pkg
module lirs_back #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_UPSAMPLE = 8,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  logic [SAMPLE_BITS-1:0]             q_sample,
    input  lirs_pkg::lirs_ctrl_t               q_ctrl,
    output logic                               q_pop,
    input  logic [lirs_pkg::STEP_BITS-1:0]     step_ratio,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [SAMPLE_BITS-1:0]             m_sample,
    output logic [lirs_pkg::OUT_CH_BITS-1:0]   m_channel,
    output logic                               m_last
);

    localparam int EFF_CH       = MAX_CHANNELS < 15 ? MAX_CHANNELS : 15;
    localparam int CH_W         = EFF_CH > 1 ? $clog2(EFF_CH) : 1;
    localparam int FRM_W        = MAX_UPSAMPLE > 1 ? $clog2(MAX_UPSAMPLE) : 1;
    localparam int PFB          = lirs_pkg::PHASE_FRAC_BITS;
    localparam int PH_W         = lirs_pkg::STEP_BITS;
    localparam int SUM_W        = PH_W + 1;
    localparam int DIFF_W       = SAMPLE_BITS + 1;
    localparam int PROD_W       = DIFF_W + PFB + 1;
    localparam int SHIFT_W      = PROD_W - PFB;
    localparam int MIN_STEP_RAW = lirs_pkg::ONE_FRAME / MAX_UPSAMPLE;
    localparam int MIN_STEP     = MIN_STEP_RAW < 1 ? 1 : MIN_STEP_RAW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FRAME = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [PH_W-1:0]          phase_reg, phase_next;
    logic                     primed_reg, primed_next;
    logic [CH_W-1:0]          ch_reg, ch_next;
    logic [CH_W-1:0]          chans_m1_reg, chans_m1_next;
    logic [FRM_W-1:0]         frames_reg, frames_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0]   m_sample_reg, m_sample_next;
    logic [lirs_pkg::OUT_CH_BITS-1:0] m_channel_reg, m_channel_next;
    logic                     m_last_reg, m_last_next;

    logic [SAMPLE_BITS-1:0]   prev_reg [EFF_CH];
    logic [SAMPLE_BITS-1:0]   cur_reg  [EFF_CH];

    logic                     prev_clear;
    logic                     prev_copy;
    logic                     cur_we;
    logic                     out_free;
    logic                     last_ch;
    logic                     more_frames;
    logic [PH_W-1:0]          step_eff;
    logic [SUM_W-1:0]         phase_sum;
    logic [SAMPLE_BITS-1:0]   cur_sel;
    logic [SAMPLE_BITS-1:0]   prev_sel;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] product;
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [SHIFT_W-1:0] out_wide;

    assign step_eff  = (step_ratio < PH_W'(MIN_STEP)) ? PH_W'(MIN_STEP) : step_ratio;
    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_eff};
    assign last_ch   = ch_reg == chans_m1_reg;
    assign more_frames = (phase_sum < SUM_W'(lirs_pkg::ONE_FRAME))
                      && (frames_reg != FRM_W'(MAX_UPSAMPLE - 1));
    assign out_free  = !m_valid_reg || m_ready;

    assign cur_sel  = cur_reg[ch_reg];
    assign prev_sel = prev_reg[ch_reg];
    assign diff     = $signed({cur_sel[SAMPLE_BITS-1], cur_sel})
                    - $signed({prev_sel[SAMPLE_BITS-1], prev_sel});
    assign product  = diff * $signed({1'b0, phase_reg[PFB-1:0]});
    // arithmetic shift of the product gives the floored fraction
    assign shifted  = prod_reg[PROD_W-1:PFB];
    assign out_wide = $signed({{2{prev_sel[SAMPLE_BITS-1]}}, prev_sel}) + shifted;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        primed_next    = primed_reg;
        ch_next        = ch_reg;
        chans_m1_next  = chans_m1_reg;
        frames_next    = frames_reg;
        prod_next      = prod_reg;
        m_sample_next  = m_sample_reg;
        m_channel_next = m_channel_reg;
        m_last_next    = m_last_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        q_pop          = 1'b0;
        prev_clear     = 1'b0;
        prev_copy      = 1'b0;
        cur_we         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop  = 1'b1;
                    cur_we = 1'b1;
                    if (q_ctrl.restart) begin
                        prev_clear  = 1'b1;
                        phase_next  = '0;
                        primed_next = 1'b0;
                    end
                    if (q_ctrl.complete) begin
                        chans_m1_next = q_ctrl.chan_last[CH_W-1:0];
                        state_next    = ST_FRAME;
                    end
                end
            end
            ST_FRAME: begin
                if (!primed_reg) begin
                    // first frame only becomes history
                    prev_copy   = 1'b1;
                    primed_next = 1'b1;
                    state_next  = ST_IDLE;
                end else if (phase_reg < PH_W'(lirs_pkg::ONE_FRAME)) begin
                    ch_next     = '0;
                    frames_next = '0;
                    state_next  = ST_MUL;
                end else begin
                    phase_next = PH_W'(phase_reg - PH_W'(lirs_pkg::ONE_FRAME));
                    prev_copy  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                prod_next  = product;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_sample_next  = out_wide[SAMPLE_BITS-1:0];
                    m_channel_next = lirs_pkg::OUT_CH_BITS'(ch_reg);
                    m_last_next    = last_ch && !more_frames;
                    if (!last_ch) begin
                        ch_next    = CH_W'(ch_reg + 1'b1);
                        state_next = ST_MUL;
                    end else if (more_frames) begin
                        phase_next  = phase_sum[PH_W-1:0];
                        frames_next = FRM_W'(frames_reg + 1'b1);
                        ch_next     = '0;
                        state_next  = ST_MUL;
                    end else begin
                        if (phase_sum >= SUM_W'(lirs_pkg::ONE_FRAME)) begin
                            phase_next = PH_W'(phase_sum - SUM_W'(lirs_pkg::ONE_FRAME));
                        end else begin
                            phase_next = '0;
                        end
                        prev_copy  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            primed_reg  <= 1'b0;
            ch_reg      <= '0;
            frames_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            primed_reg  <= primed_next;
            ch_reg      <= ch_next;
            frames_reg  <= frames_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chans_m1_reg  <= chans_m1_next;
        prod_reg      <= prod_next;
        m_sample_reg  <= m_sample_next;
        m_channel_reg <= m_channel_next;
        m_last_reg    <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < EFF_CH; i++) begin
                prev_reg[i] <= '0;
            end
        end else if (prev_clear) begin
            for (int i = 0; i < EFF_CH; i++) begin
                prev_reg[i] <= '0;
            end
        end else if (prev_copy) begin
            for (int i = 0; i < EFF_CH; i++) begin
                if (CH_W'(i) <= chans_m1_reg) begin
                    prev_reg[i] <= cur_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_reg[q_ctrl.slot[CH_W-1:0]] <= q_sample;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;
    assign m_channel = m_channel_reg;
    assign m_last    = m_last_reg;

endmodule

/* sv/lirs_checker.sv */
// port-level checks for the linear interpolation resampler, bound to the top level
// depends on linear_interp_resampler_core_assert.svh and lirs_pkg
`include "linear_interp_resampler_core_assert.svh"

module lirs_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
    input logic                                s_tuser,  // restart
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,  // out_sample
    input logic [lirs_pkg::OUT_CH_BITS-1:0]    m_tuser,  // out_channel
    input logic                                m_tlast,  // last_of_run
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [lirs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input logic [lirs_pkg::STEP_BITS-1:0]      cfg_data
);

    // a stalled result keeps its whole payload
    `LIRS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // reset drops any pending result
    `LIRS_ASSERT_NEXT_ALWAYS(a_reset_out, aclk, !aresetn, !m_tvalid)

    // reset empties the queue so the input side is open straight away
    `LIRS_ASSERT_NEXT_ALWAYS(a_reset_in, aclk, !aresetn, s_tready)

endmodule

bind linear_interp_resampler_core lirs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lirs_checker (.*);
